@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the decoder RTL.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

@@ hw/rtl/pdwd_pkg.sv @@
// ----------------------------------------------------------------------------
// pdwd_pkg
// Shared constants and types for the predictive delta word decoder.
// ----------------------------------------------------------------------------
package pdwd_pkg;

   localparam int NCH_MAX      = 4;
   localparam int CHANNELS_DEF = 4;
   localparam int BYTE_W       = 8;
   localparam int WORD_W       = 16;
   localparam int CODE_W       = 2;
   localparam int POS_W        = 2;
   localparam int PHASE_W      = 2;

   // parser phases
   localparam logic [PHASE_W-1:0] PH_TAG    = 2'd0;
   localparam logic [PHASE_W-1:0] PH_DELTA  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_LIT_LO = 2'd2;
   localparam logic [PHASE_W-1:0] PH_LIT_HI = 2'd3;

   // channel codes carrying data (codes 0 and 1 are prediction only)
   localparam logic [CODE_W-1:0] CODE_DELTA = 2'd2;
   localparam logic [CODE_W-1:0] CODE_LIT   = 2'd3;

   // one input item
   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              start_stream;
   } item_type;

   // one decoded group, channel 0 in the low slot
   typedef logic [NCH_MAX-1:0][WORD_W-1:0] words_type;

endpackage

@@ hw/rtl/pdwd_core.sv @@
// ----------------------------------------------------------------------------
// pdwd_core
// Stream parser and channel history; decodes one byte per enabled cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdwd_core #(
   parameter int CHANNELS = pdwd_pkg::CHANNELS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  pdwd_pkg::item_type  item,
   output logic                emit,
   output pdwd_pkg::words_type words
);

   localparam int W = pdwd_pkg::WORD_W;

   logic [pdwd_pkg::PHASE_W-1:0] phase_ff, phase_in;
   logic [pdwd_pkg::BYTE_W-1:0]  tag_ff, tag_in;
   logic [pdwd_pkg::POS_W-1:0]   chan_pos_ff, chan_pos_in;
   logic [pdwd_pkg::BYTE_W-1:0]  low_ff, low_in;
   logic [W-1:0] cur_ff[CHANNELS], cur_in[CHANNELS];
   logic [W-1:0] prv_ff[CHANNELS], prv_in[CHANNELS];
   logic [W-1:0] pp_ff[CHANNELS],  pp_in[CHANNELS];

   logic [W-1:0]                 pred[CHANNELS];
   logic [W-1:0]                 delta_ext;
   logic                         resolve_en;
   logic                         found;
   logic [pdwd_pkg::POS_W:0]     rpos;
   logic [pdwd_pkg::CODE_W-1:0]  code;

   assign delta_ext = {{(W - pdwd_pkg::BYTE_W){item.in_byte[pdwd_pkg::BYTE_W-1]}},
                       item.in_byte};

   // decode step: optional clear, consume byte, resolve prediction channels
   always_comb begin
      phase_in    = phase_ff;
      tag_in      = tag_ff;
      chan_pos_in = chan_pos_ff;
      low_in      = low_ff;
      cur_in      = cur_ff;
      prv_in      = prv_ff;
      pp_in       = pp_ff;
      emit        = 1'b0;
      resolve_en  = 1'b0;
      found       = 1'b0;
      rpos        = '0;
      code        = '0;
      words       = '0;

      if (item.start_stream) begin
         phase_in    = pdwd_pkg::PH_TAG;
         tag_in      = '0;
         chan_pos_in = '0;
         low_in      = '0;
         for (int i = 0; i < CHANNELS; i++) begin
            cur_in[i] = '0;
            prv_in[i] = '0;
            pp_in[i]  = '0;
         end
      end

      // second-order prediction per channel, mod 2^16
      for (int i = 0; i < CHANNELS; i++) begin
         pred[i] = W'({prv_in[i], 1'b0} - {1'b0, pp_in[i]});
      end

      if (advance) begin
         case (phase_in)
            pdwd_pkg::PH_TAG: begin
               tag_in     = item.in_byte;
               resolve_en = 1'b1;
               rpos       = '0;
            end
            pdwd_pkg::PH_DELTA: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  if (chan_pos_in == pdwd_pkg::POS_W'(i)) begin
                     cur_in[i] = pred[i] + delta_ext;
                  end
               end
               resolve_en = 1'b1;
               rpos       = {1'b0, chan_pos_in} + 3'd1;
            end
            pdwd_pkg::PH_LIT_LO: begin
               low_in   = item.in_byte;
               phase_in = pdwd_pkg::PH_LIT_HI;
            end
            default: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  if (chan_pos_in == pdwd_pkg::POS_W'(i)) begin
                     cur_in[i] = {item.in_byte, low_in};
                     prv_in[i] = {item.in_byte, low_in};
                     pp_in[i]  = {item.in_byte, low_in};
                  end
               end
               resolve_en = 1'b1;
               rpos       = {1'b0, chan_pos_in} + 3'd1;
            end
         endcase

         // priority pick of the next data channel; earlier ones take the prediction
         if (resolve_en) begin
            for (int i = 0; i < CHANNELS; i++) begin
               code = tag_in[2*i +: 2];
               if (!found && (3'(i) >= rpos)) begin
                  if (code == pdwd_pkg::CODE_DELTA || code == pdwd_pkg::CODE_LIT) begin
                     found       = 1'b1;
                     chan_pos_in = pdwd_pkg::POS_W'(i);
                     phase_in    = (code == pdwd_pkg::CODE_DELTA) ? pdwd_pkg::PH_DELTA
                                                                  : pdwd_pkg::PH_LIT_LO;
                  end else begin
                     cur_in[i] = pred[i];
                  end
               end
            end
            // group complete: emit and shift history
            if (!found) begin
               emit        = 1'b1;
               chan_pos_in = '0;
               phase_in    = pdwd_pkg::PH_TAG;
               for (int i = 0; i < CHANNELS; i++) begin
                  words[i]  = cur_in[i];
                  pp_in[i]  = prv_in[i];
                  prv_in[i] = cur_in[i];
               end
            end
         end
      end else begin
         // hold state; a start flag only counts on a processed item
         phase_in    = phase_ff;
         tag_in      = tag_ff;
         chan_pos_in = chan_pos_ff;
         low_in      = low_ff;
         cur_in      = cur_ff;
         prv_in      = prv_ff;
         pp_in       = pp_ff;
      end
   end

   // parser and history registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= pdwd_pkg::PH_TAG;
         tag_ff      <= '0;
         chan_pos_ff <= '0;
         low_ff      <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            cur_ff[i] <= '0;
            prv_ff[i] <= '0;
            pp_ff[i]  <= '0;
         end
      end else begin
         phase_ff    <= phase_in;
         tag_ff      <= tag_in;
         chan_pos_ff <= chan_pos_in;
         low_ff      <= low_in;
         cur_ff      <= cur_in;
         prv_ff      <= prv_in;
         pp_ff       <= pp_in;
      end
   end

   // a finished group always returns the parser to the tag
   `ASSERT_PROP(a_emit_to_tag, clock, reset,
      emit |=> (phase_ff == pdwd_pkg::PH_TAG && chan_pos_ff == '0))
   // a channel waiting for data is always an enabled channel
   `ASSERT_NEVER(a_pos_range, clock, reset,
      phase_ff != pdwd_pkg::PH_TAG && {1'b0, chan_pos_ff} >= 3'(CHANNELS))
   // the literal high byte only follows a literal low byte
   `ASSERT_PROP(a_lit_order, clock, reset,
      (phase_ff == pdwd_pkg::PH_LIT_HI && !$past(reset))
         |-> ($past(phase_ff) == pdwd_pkg::PH_LIT_LO || $past(phase_ff) == pdwd_pkg::PH_LIT_HI))

endmodule

@@ hw/rtl/predictive_delta_word_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// predictive_delta_word_decoder_unit
// Decodes a tagged byte stream into groups of 16-bit channel words.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one stream byte per item plus a start flag that clears the
//   channel history and makes the byte a tag. rsp_* carries one decoded group
//   (rsp_word0..rsp_word3) per item; channels at or above CHANNELS read zero.
//   A byte produces zero or one group: the group leaves on the byte that
//   resolves its last channel.
//   Throughput: one byte per cycle while rsp_* is not stalled; an input register
//   feeds the decode step, whose result lands in the output register.
//   Stall: while rsp_valid is high and rsp_ready low the byte held in the
//   input register waits, and req_ready falls once that register is full.
//   Reset: clears the parser (next byte is a tag), the history and both
//   registers' valid flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module predictive_delta_word_decoder_unit #(
   parameter int CHANNELS = pdwd_pkg::CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [pdwd_pkg::BYTE_W-1:0]     req_in_byte,
   input  logic                            req_start_stream,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [pdwd_pkg::WORD_W-1:0]     rsp_word0,
   output logic [pdwd_pkg::WORD_W-1:0]     rsp_word1,
   output logic [pdwd_pkg::WORD_W-1:0]     rsp_word2,
   output logic [pdwd_pkg::WORD_W-1:0]     rsp_word3
);

   logic                in_valid_ff, in_valid_in;
   pdwd_pkg::item_type  in_ff, in_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pdwd_pkg::words_type words_ff, words_in;
   pdwd_pkg::words_type words;
   logic                out_free;
   logic                advance;
   logic                emit;

   // handshake control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_in       = '{in_byte: req_in_byte, start_stream: req_start_stream};
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      words_in     = words_ff;
      if (out_free) begin
         rsp_valid_in = advance && emit;
         words_in     = words;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff    <= in_in;
      words_ff <= words_in;
   end

   // decode step
   pdwd_core #(
      .CHANNELS (CHANNELS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_ff),
      .emit    (emit),
      .words   (words)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word0 = words_ff[0];
   assign rsp_word1 = words_ff[1];
   assign rsp_word2 = words_ff[2];
   assign rsp_word3 = words_ff[3];

   // the input side only stalls behind a stalled result
   `ASSERT_PROP(a_stall_cause, clock, reset,
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
   // a decoded byte never lands on a result that is still waiting
   `ASSERT_NEVER(a_no_overrun, clock, reset, advance && rsp_valid_ff && !rsp_ready)

endmodule

@@ tb/decoded_group_checker.sv @@
// ----------------------------------------------------------------------------
// decoded_group_checker
// Watches both channels of the delta word decoder. Every accepted stream byte
// runs through a second-order prediction decoder kept here; every group it
// completes is queued and compared word by word with the next group the
// block hands out.
// ----------------------------------------------------------------------------
module decoded_group_checker
   import pdwd_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic [BYTE_W-1:0] req_in_byte,
   input  logic              req_start_stream,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [WORD_W-1:0] rsp_word0,
   input  logic [WORD_W-1:0] rsp_word1,
   input  logic [WORD_W-1:0] rsp_word2,
   input  logic [WORD_W-1:0] rsp_word3,
   output int                fail_count,
   output int                groups_checked,
   output int                groups_pending
);

   localparam int MAX_REPORTS = 20;

   // decoder state
   logic [PHASE_W-1:0] parse_phase;
   logic [BYTE_W-1:0]  group_tag;
   logic [POS_W-1:0]   wait_chan;
   logic [BYTE_W-1:0]  literal_low;
   logic [WORD_W-1:0]  cur_word [NCH_MAX];
   logic [WORD_W-1:0] last_word [NCH_MAX];
   logic [WORD_W-1:0] older_word [NCH_MAX];

   words_type expected_groups[$];

   function automatic logic [CODE_W-1:0] code_at(int ch);
      return group_tag[CODE_W*ch +: CODE_W];
   endfunction

   // linear extrapolation from the two previous words, mod 2^16
   function automatic logic [WORD_W-1:0] extrapolate(int ch);
      logic [WORD_W-1:0] twice;
      twice = {last_word[ch][WORD_W-2:0], 1'b0};
      return twice - older_word[ch];
   endfunction

   task automatic wipe_history();
      parse_phase = PH_TAG;
      group_tag   = '0;
      wait_chan   = '0;
      literal_low = '0;
      for (int i = 0; i < NCH_MAX; i++) begin
         cur_word[i]   = '0;
         last_word[i]  = '0;
         older_word[i] = '0;
      end
   endtask

   // fill prediction-only channels from ch on; queue the group once complete
   task automatic settle_channels(int ch);
      words_type grp;
      while (ch < CHANNELS && code_at(ch) < CODE_DELTA) begin
         cur_word[ch] = extrapolate(ch);
         ch++;
      end
      if (ch < CHANNELS) begin
         wait_chan   = ch[POS_W-1:0];
         parse_phase = (code_at(ch) == CODE_DELTA) ? PH_DELTA : PH_LIT_LO;
      end else begin
         grp = '0;
         for (int i = 0; i < CHANNELS; i++) grp[i] = cur_word[i];
         expected_groups.push_back(grp);
         for (int i = 0; i < CHANNELS; i++) begin
            older_word[i] = last_word[i];
            last_word[i]  = cur_word[i];
         end
         wait_chan   = '0;
         parse_phase = PH_TAG;
      end
   endtask

   // one stream byte through the decoder
   task automatic decode_byte(logic [BYTE_W-1:0] b, logic restart);
      logic [WORD_W-1:0] lit;
      int ch;
      if (restart) wipe_history();
      ch = int'(wait_chan);
      case (parse_phase)
         PH_TAG: begin
            group_tag = b;
            settle_channels(0);
         end
         PH_DELTA: begin
            cur_word[ch] = extrapolate(ch) + {{(WORD_W-BYTE_W){b[BYTE_W-1]}}, b};
            settle_channels(ch + 1);
         end
         PH_LIT_LO: begin
            literal_low = b;
            parse_phase = PH_LIT_HI;
         end
         default: begin
            lit = {b, literal_low};
            cur_word[ch]   = lit;
            last_word[ch]  = lit;
            older_word[ch] = lit;
            settle_channels(ch + 1);
         end
      endcase
   endtask

   // responses are checked before the byte of the same edge is decoded
   always @(posedge clock) begin : watch
      words_type seen;
      words_type want;
      if (reset) begin
         wipe_history();
         expected_groups.delete();
         fail_count     = 0;
         groups_checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_word3, rsp_word2, rsp_word1, rsp_word0};
            if (expected_groups.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: unexpected group, expected none, got %h %h %h %h",
                           $time, seen[0], seen[1], seen[2], seen[3]);
            end else begin
               want = expected_groups.pop_front();
               groups_checked++;
               for (int i = 0; i < NCH_MAX; i++) begin
                  if (seen[i] !== want[i]) begin
                     fail_count++;
                     if (fail_count <= MAX_REPORTS)
                        $display("%0t: group %0d word%0d expected %h, got %h",
                                 $time, groups_checked, i, want[i], seen[i]);
                  end
               end
            end
         end
         if (req_valid && req_ready) decode_byte(req_in_byte, req_start_stream);
      end
      groups_pending = expected_groups.size();
   end

endmodule

@@ tb/tb_predictive_delta_word_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// tb_predictive_delta_word_decoder_unit
// Drives tagged byte streams into the delta word decoder: a directed set of
// tags (all-prediction, all-delta, all-literal, mixed, restart mid-group)
// followed by random groups, some cut short by a restart. Pacing on both
// channels changes across four phases. Checking is done by the group checker.
// ----------------------------------------------------------------------------
module tb_predictive_delta_word_decoder_unit;
   import pdwd_pkg::*;

   localparam int BYTE_TARGET = 700;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 4;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [BYTE_W-1:0] req_in_byte;
   logic              req_start_stream;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [WORD_W-1:0] rsp_word0;
   logic [WORD_W-1:0] rsp_word1;
   logic [WORD_W-1:0] rsp_word2;
   logic [WORD_W-1:0] rsp_word3;

   int fail_count;
   int groups_checked;
   int groups_pending;
   int bytes_sent;
   int idle_cycles;
   int send_idle_pct;
   int recv_stall_pct;
   bit restart_due;

   // pacing per phase: none, sender sparse, receiver stalling, both light
   int send_pct_by_phase [4] = '{0, 88, 0, 15};
   int stall_pct_by_phase[4] = '{0, 0, 88, 15};

   predictive_delta_word_decoder_unit #(.CHANNELS(CHANNELS_DEF)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_start_stream (req_start_stream),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word0        (rsp_word0),
      .rsp_word1        (rsp_word1),
      .rsp_word2        (rsp_word2),
      .rsp_word3        (rsp_word3)
   );

   decoded_group_checker #(.CHANNELS(CHANNELS_DEF)) checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_start_stream (req_start_stream),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word0        (rsp_word0),
      .rsp_word1        (rsp_word1),
      .rsp_word2        (rsp_word2),
      .rsp_word3        (rsp_word3),
      .fail_count       (fail_count),
      .groups_checked   (groups_checked),
      .groups_pending   (groups_pending)
   );

   always #2 clock = ~clock;

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // watchdog: cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one byte onto the request channel, with random idle cycles ahead of it
   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid        <= 1'b0;
         req_in_byte      <= BYTE_W'($urandom);
         req_start_stream <= 1'($urandom);
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_in_byte      <= b;
      req_start_stream <= restart;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   // random tag plus its data bytes; now and then cut short by a restart
   task automatic random_group();
      logic [BYTE_W-1:0] tag;
      logic [BYTE_W-1:0] b;
      logic [CODE_W-1:0] code;
      bit   no_literals;
      int   data_bytes;
      int   keep;
      no_literals = ($urandom_range(3) == 0);
      data_bytes  = 0;
      for (int ch = 0; ch < NCH_MAX; ch++) begin
         code = no_literals ? CODE_W'($urandom_range(2)) : CODE_W'($urandom_range(3));
         tag[CODE_W*ch +: CODE_W] = code;
         if (code == CODE_DELTA) data_bytes += 1;
         else if (code == CODE_LIT) data_bytes += 2;
      end
      push_byte(tag, restart_due || ($urandom_range(14) == 0));
      restart_due = 1'b0;
      keep = data_bytes;
      if (data_bytes > 0 && $urandom_range(19) == 0) begin
         keep        = $urandom_range(data_bytes - 1);
         restart_due = 1'b1;
      end
      for (int i = 0; i < keep; i++) begin
         case ($urandom_range(9))
            0:       b = 8'h7f;
            1:       b = 8'h80;
            2:       b = 8'hff;
            3:       b = 8'h00;
            default: b = BYTE_W'($urandom);
         endcase
         push_byte(b, 1'b0);
      end
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_in_byte      = '0;
      req_start_stream = 1'b0;
      rsp_ready        = 1'b0;
      bytes_sent       = 0;
      idle_cycles      = 0;
      restart_due      = 1'b0;
      send_idle_pct    = send_pct_by_phase[0];
      recv_stall_pct   = stall_pct_by_phase[0];
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // all channels predicted: group leaves with the tag itself
      push_byte(8'h00, 1'b1);
      // all literals: zero, all ones, sign bit only, largest positive
      push_byte(8'hff, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'h7f, 1'b0);
      // all deltas: both byte extremes, minus one and plus one
      push_byte(8'haa, 1'b0);
      push_byte(8'h7f, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'hff, 1'b0);
      push_byte(8'h01, 1'b0);
      // code one on every channel behaves as a prediction
      push_byte(8'h55, 1'b0);
      // one of each code: ch2 delta, ch3 literal
      push_byte(8'he4, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h34, 1'b0);
      push_byte(8'h12, 1'b0);
      // restart in the middle of a group drops it and clears history
      push_byte(8'hff, 1'b1);
      push_byte(8'h11, 1'b0);
      push_byte(8'h22, 1'b0);
      push_byte(8'h00, 1'b1);

      // random groups across the four pacing phases
      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = send_pct_by_phase[p];
         recv_stall_pct = stall_pct_by_phase[p];
         while (bytes_sent < (p + 1) * BYTE_TARGET / 4) random_group();
      end

      // drain
      req_valid <= 1'b0;
      recv_stall_pct = 0;
      while (groups_pending != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Summary: %0d stream bytes sent over four pacing phases, %0d groups compared",
               bytes_sent, groups_checked);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/pdwd_pkg.sv
hw/rtl/pdwd_core.sv
hw/rtl/predictive_delta_word_decoder_unit.sv
tb/decoded_group_checker.sv
tb/tb_predictive_delta_word_decoder_unit.sv
